/* hdl/tvpr_pkg.sv */
`timescale 1ns / 1ps
package tvpr_pkg;

    localparam int HistDepth = 3;
    localparam int HistIdxW  = $clog2(HistDepth);
    localparam int CntW      = $clog2(HistDepth + 1);
    localparam int MsPerS    = 1000;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        CMD_DOWN = 2'd0,
        CMD_LIFT = 2'd1,
        CMD_MOVE = 2'd2,
        CMD_TICK = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LANE_LEFT_X   = 3'd0,
        REG_LANE_TOP_Y    = 3'd1,
        REG_PULL_LIMIT    = 3'd2,
        REG_PIXELS_NOTCH  = 3'd3,
        REG_NOTCH_LIMIT   = 3'd4,
        REG_STALE_TIMEOUT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [9:0]  lane_left_x;
        logic [9:0]  lane_top_y;
        logic [9:0]  pull_limit;
        logic [7:0]  pixels_per_notch;
        logic [7:0]  notch_limit;
        logic [15:0] stale_timeout;
    } cfg_t;

    typedef struct packed {
        logic        finger_down;
        logic [9:0]  finger_x;
        logic [9:0]  finger_y;
        logic [15:0] speed_x;
        logic [15:0] speed_y;
        logic        pull_active;
        logic [9:0]  pull_px;
        logic [7:0]  pull_notches;
        logic [7:0]  notch_step;
        logic        release_valid;
        logic [9:0]  release_pull;
        logic [7:0]  release_notches;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPEED_X,
        ST_SPEED_Y,
        ST_NOTCH,
        ST_FINISH,
        ST_OUT
    } exec_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

/* hdl/tvpr_divider.sv */
`timescale 1ns / 1ps
// Restoring divider for magnitudes: 41-bit dividend by 32-bit divisor, one bit per cycle.
module tvpr_divider
    import tvpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [40:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [40:0] quotient
);

    div_state_t  state_reg, state_next;
    logic [5:0]  count_reg, count_next;
    logic [40:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg[31:0], quo_reg[40]} - {1'b0, divisor};
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    quo_next   = dividend;
                    rem_next   = '0;
                    count_next = 6'd41;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (!trial[32])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[39:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[31:0], quo_reg[40]};
                    quo_next = {quo_reg[39:0], 1'b0};
                end
                count_next = count_reg - 6'd1;
                if (count_reg == 6'd1)
                    state_next = DIV_DONE;
            end
            DIV_DONE:
                state_next = DIV_IDLE;
            default:
                state_next = DIV_IDLE;
        endcase
    end

    assign done     = (state_reg == DIV_DONE);
    assign quotient = quo_reg;

endmodule

/* hdl/tvpr_front.sv */
`timescale 1ns / 1ps
// Input side: registers the configuration and queues accepted items.
module tvpr_front
    import tvpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg,
    output logic        q_valid,
    input  logic        q_pop,
    output item_t       q_item
);

    item_t       mem_reg [QueueDepth];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;
    cfg_t        cfg_reg;
    logic        push;

    assign in_ready  = (fill_reg != 2'(QueueDepth));
    assign push      = in_valid && in_ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign q_item    = mem_reg[rd_ptr_reg];
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
            cfg_reg    <= '{10'd0, 10'd0, 10'd64, 8'd8, 8'd8, 16'd500};
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(q_pop);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_LANE_LEFT_X:   cfg_reg.lane_left_x      <= cfg_data[9:0];
                    REG_LANE_TOP_Y:    cfg_reg.lane_top_y       <= cfg_data[9:0];
                    REG_PULL_LIMIT:    cfg_reg.pull_limit       <= cfg_data[9:0];
                    REG_PIXELS_NOTCH:  cfg_reg.pixels_per_notch <= cfg_data[7:0];
                    REG_NOTCH_LIMIT:   cfg_reg.notch_limit      <= cfg_data[7:0];
                    REG_STALE_TIMEOUT: cfg_reg.stale_timeout    <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* hdl/tvpr_back.sv */
`timescale 1ns / 1ps
// Execution side: state update, two velocity divisions and one notch division.
module tvpr_back
    import tvpr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_pop,
    input  item_t   q_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res
);

    exec_state_t state_reg, state_next;
    item_t       it_reg, it_next;
    result_t     res_reg, res_next;

    logic             down_reg, down_next;
    logic [9:0]       last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [9:0]       hx_reg [HistDepth], hy_reg [HistDepth];
    logic [31:0]      ht_reg [HistDepth];
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [15:0]      vx_reg, vx_next, vy_reg, vy_next;
    logic [31:0]      let_reg, let_next;
    logic             ga_reg, ga_next;
    logic [9:0]       gsy_reg, gsy_next, gp_reg, gp_next;
    logic [7:0]       gn_reg, gn_next;
    logic             push_next;
    logic             dx_reg, dx_next;
    logic [31:0]      dt_reg, dt_next;

    logic             div_start;
    logic [40:0]      div_dividend, div_q;
    logic [31:0]      div_divisor;
    logic             div_done;

    logic [HistIdxW-1:0] old_idx;
    logic [31:0]      diff;
    logic             begin_ok;
    logic signed [10:0] delta;
    logic [10:0]      dmag;
    logic [40:0]      qmag;
    logic [15:0]      sat;
    logic [9:0]       pull_dist;
    logic [7:0]       ntch;

    tvpr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            down_reg   <= 1'b0;
            last_x_reg <= '0;
            last_y_reg <= '0;
            cnt_reg    <= '0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            let_reg    <= '0;
            ga_reg     <= 1'b0;
            gsy_reg    <= '0;
            gp_reg     <= '0;
            gn_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            down_reg   <= down_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            cnt_reg    <= cnt_next;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            let_reg    <= let_next;
            ga_reg     <= ga_next;
            gsy_reg    <= gsy_next;
            gp_reg     <= gp_next;
            gn_reg     <= gn_next;
        end
    end

    // The new sample enters the history at the same edge that registers the item.
    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        res_reg  <= res_next;
        dx_reg   <= dx_next;
        dt_reg   <= dt_next;
        if (push_next)
        begin
            for (int i = HistDepth - 1; i > 0; i--)
            begin
                hx_reg[i] <= hx_reg[i-1];
                hy_reg[i] <= hy_reg[i-1];
                ht_reg[i] <= ht_reg[i-1];
            end
            hx_reg[0] <= it_next.pos_x;
            hy_reg[0] <= it_next.pos_y;
            ht_reg[0] <= it_next.time_ms;
        end
    end

    // Oldest kept sample once the new one sits at index 0.
    assign old_idx = (cnt_reg >= CntW'(HistDepth)) ? HistIdxW'(HistDepth - 1)
                                                   : HistIdxW'(cnt_reg - CntW'(1));
    assign diff    = ht_reg[0] - ht_reg[old_idx];
    assign begin_ok = (it_reg.pos_x >= cfg.lane_left_x) && (it_reg.pos_y >= cfg.lane_top_y);
    assign delta   = dx_reg ? ($signed({1'b0, hx_reg[0]}) - $signed({1'b0, hx_reg[old_idx]}))
                            : ($signed({1'b0, hy_reg[0]}) - $signed({1'b0, hy_reg[old_idx]}));
    assign dmag    = delta[10] ? 11'(-delta) : 11'(delta);
    assign qmag    = div_q;
    assign pull_dist = (it_reg.pos_y > gsy_reg) ? it_reg.pos_y - gsy_reg : 10'd0;

    always_comb
    begin
        if (delta[10])
            sat = (qmag > 41'd32768) ? 16'h8000 : 16'(-qmag[15:0]);
        else
            sat = (qmag > 41'd32767) ? 16'h7FFF : qmag[15:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        it_next     = it_reg;
        res_next    = res_reg;
        down_next   = down_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        cnt_next    = cnt_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        let_next    = let_reg;
        ga_next     = ga_reg;
        gsy_next    = gsy_reg;
        gp_next     = gp_reg;
        gn_next     = gn_reg;
        push_next   = 1'b0;
        dx_next     = dx_reg;
        dt_next     = dt_reg;
        q_pop       = 1'b0;
        div_start   = 1'b0;
        div_dividend = 41'(dmag) * 41'(MsPerS);
        div_divisor  = dt_reg;
        ntch        = 8'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop   = 1'b1;
                    it_next = q_item;
                    res_next.notch_step      = '0;
                    res_next.release_valid   = 1'b0;
                    res_next.release_pull    = '0;
                    res_next.release_notches = '0;
                    unique case (q_item.cmd) inside
                        CMD_DOWN, CMD_MOVE:
                        begin
                            last_x_next = q_item.pos_x;
                            last_y_next = q_item.pos_y;
                            let_next    = q_item.time_ms;
                            push_next   = 1'b1;
                            if (q_item.cmd == CMD_DOWN || !down_reg)
                            begin
                                cnt_next = CntW'(1);
                                // pull begin decided in ST_SPEED_X with the item registered
                                dx_next  = 1'b1;
                            end
                            else
                            begin
                                cnt_next = (cnt_reg < CntW'(HistDepth)) ? cnt_reg + CntW'(1)
                                                                        : cnt_reg;
                                dx_next  = 1'b0;
                            end
                            down_next  = 1'b1;
                            state_next = ST_SPEED_X;
                        end
                        CMD_LIFT:
                        begin
                            down_next  = 1'b0;
                            let_next   = q_item.time_ms;
                            state_next = ST_FINISH;
                            if (ga_reg)
                            begin
                                ga_next = 1'b0;
                                gp_next = '0;
                                gn_next = '0;
                                if (gp_reg != '0)
                                begin
                                    res_next.release_valid   = 1'b1;
                                    res_next.release_pull    = gp_reg;
                                    res_next.release_notches = gn_reg;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                            if (down_reg && let_reg != '0 &&
                                (q_item.time_ms - let_reg) > {16'd0, cfg.stale_timeout})
                            begin
                                down_next = 1'b0;
                                if (ga_reg)
                                begin
                                    ga_next = 1'b0;
                                    gp_next = '0;
                                    gn_next = '0;
                                    if (gp_reg != '0)
                                    begin
                                        res_next.release_valid   = 1'b1;
                                        res_next.release_pull    = gp_reg;
                                        res_next.release_notches = gn_reg;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            ST_SPEED_X:
            begin
                // History has been pushed; dx_reg flags a restart for pull begin.
                if (dx_reg && begin_ok)
                begin
                    ga_next  = 1'b1;
                    gsy_next = it_reg.pos_y;
                    gp_next  = '0;
                    gn_next  = '0;
                end
                dx_next = 1'b1;
                if (it_reg.cmd == CMD_DOWN)
                    state_next = ST_FINISH;
                else if (cnt_reg < CntW'(2))
                begin
                    vx_next = '0;
                    vy_next = '0;
                    state_next = ST_NOTCH;
                end
                else if (diff == '0 || diff[31])
                    state_next = ST_NOTCH;
                else
                begin
                    dt_next    = diff;
                    state_next = ST_SPEED_Y;
                end
            end
            ST_SPEED_Y:
            begin
                // dx_reg high: running x, else y. The divider starts on entry and again for y once x is done.
                if (div_done)
                begin
                    if (dx_reg)
                    begin
                        vx_next = sat;
                        dx_next = 1'b0;
                    end
                    else
                    begin
                        vy_next    = sat;
                        state_next = ST_NOTCH;
                    end
                end
                else
                    div_start = 1'b1;
            end
            ST_NOTCH:
            begin
                if (ga_reg)
                begin
                    if (!div_done)
                    begin
                        div_divisor  = (cfg.pixels_per_notch == '0) ? 32'd1
                                                                    : 32'(cfg.pixels_per_notch);
                        gp_next   = (pull_dist > cfg.pull_limit) ? cfg.pull_limit : pull_dist;
                        div_dividend = 41'(gp_next);
                        div_start = 1'b1;
                    end
                    else
                    begin
                        ntch = (div_q > 41'(cfg.notch_limit)) ? cfg.notch_limit : div_q[7:0];
                        if (ntch > gn_reg)
                        begin
                            res_next.notch_step = ntch - gn_reg;
                            gn_next = ntch;
                        end
                        state_next = ST_FINISH;
                    end
                end
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                res_next.finger_down  = down_reg;
                res_next.finger_x     = last_x_reg;
                res_next.finger_y     = last_y_reg;
                res_next.speed_x      = vx_reg;
                res_next.speed_y      = vy_reg;
                res_next.pull_active  = ga_reg;
                res_next.pull_px      = gp_reg;
                res_next.pull_notches = gn_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

endmodule

/* hdl/touch_velocity_and_pull_ratchet.sv */
`timescale 1ns / 1ps
// Touch tracker with velocity estimate and pull ratchet. Items transfer into a
// two-entry queue, so a new item can be taken while a result waits; the back end
// then handles one item at a time. A move may run the x and y velocity divisions
// and the notch division, which share one restoring divider, one after another.
// A result that is not taken holds the back end until out_ready is high.
// Configuration writes are taken every cycle and should be made while idle.
module touch_velocity_and_pull_ratchet
    import tvpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [9:0]  pos_x,
    input  logic [9:0]  pos_y,
    input  logic [31:0] time_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        finger_down,
    output logic [9:0]  finger_x,
    output logic [9:0]  finger_y,
    output logic signed [15:0] speed_x,
    output logic signed [15:0] speed_y,
    output logic        pull_active,
    output logic [9:0]  pull_px,
    output logic [7:0]  pull_notches,
    output logic [7:0]  notch_step,
    output logic        release_valid,
    output logic [9:0]  release_pull,
    output logic [7:0]  release_notches
);

    cfg_t    cfg;
    item_t   in_item, q_item;
    logic    q_valid, q_pop;
    result_t res;

    assign in_item = '{cmd, pos_x, pos_y, time_ms};

    tvpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    tvpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign finger_down     = res.finger_down;
    assign finger_x        = res.finger_x;
    assign finger_y        = res.finger_y;
    assign speed_x         = res.speed_x;
    assign speed_y         = res.speed_y;
    assign pull_active     = res.pull_active;
    assign pull_px         = res.pull_px;
    assign pull_notches    = res.pull_notches;
    assign notch_step      = res.notch_step;
    assign release_valid   = res.release_valid;
    assign release_pull    = res.release_pull;
    assign release_notches = res.release_notches;

endmodule

/* hdl/tvpr_checker.sv */
`timescale 1ns / 1ps
module tvpr_checker
    import tvpr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       finger_down,
    input logic       pull_active,
    input logic       release_valid,
    input logic [9:0] release_pull,
    input logic [9:0] pull_px
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_rel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && release_valid |-> release_pull != 10'd0) else $error("empty release");
    a_rel_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && release_valid |-> !pull_active) else $error("release while pulling");
    a_idle_pull: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pull_active |-> pull_px == 10'd0) else $error("stale pull");
    a_pull_finger: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pull_active |-> finger_down) else $error("pull without finger");

endmodule

bind touch_velocity_and_pull_ratchet tvpr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .finger_down   (finger_down),
    .pull_active   (pull_active),
    .release_valid (release_valid),
    .release_pull  (release_pull),
    .pull_px       (pull_px)
);
